// File: sv/bfip_pkg.sv
package bfip_pkg;

   localparam int LOG2_BITS_DEF = 18;
   localparam int HASHES_DEF    = 2;

   localparam int HASH_W   = 64;
   localparam int WORD_W   = 64;
   localparam int INDEX_W  = 12;
   localparam int OP_W     = 2;
   localparam int OFFSET_W = 6;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_PROBE  = 2'd1,
      OP_MERGE  = 2'd2,
      OP_NONE   = 2'd3
   } bfip_op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_REPLY
   } bfip_state_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // latch accepted item
      logic clear;      // write zero at clear pointer, advance it
      logic mem_rd;     // read the word under work
      logic mem_wr;     // write back the modified word
      logic check;      // fold the tested bit into the probe result
      logic hash_next;  // move to the next hash function
      logic rsp_load;   // put the probe result into the output register
   } bfip_cmd_type;

   // datapath to controller
   typedef struct packed {
      bfip_op_type op;
      logic        last_hash;
      logic        clear_last;
      logic        rsp_free;
   } bfip_sts_type;

endpackage

// File: sv/bfip_req_if.sv
interface bfip_req_if;
   logic                           valid;
   logic                           ready;
   logic [bfip_pkg::OP_W-1:0]      req_type;
   logic [bfip_pkg::HASH_W-1:0]    hash;
   logic [bfip_pkg::INDEX_W-1:0]   word_index;
   logic [bfip_pkg::WORD_W-1:0]    word_data;

   modport source (output valid, req_type, hash, word_index, word_data, input ready);
   modport sink   (input valid, req_type, hash, word_index, word_data, output ready);
endinterface

// File: sv/bfip_rsp_if.sv
interface bfip_rsp_if;
   logic valid;
   logic ready;
   logic maybe_present;

   modport source (output valid, maybe_present, input ready);
   modport sink   (input valid, maybe_present, output ready);
endinterface

// File: sv/bfip_ram.sv
module bfip_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: sv/bfip_ctrl.sv
module bfip_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  bfip_pkg::bfip_op_type  req_op,
   output logic                   req_ready,
   input  bfip_pkg::bfip_sts_type sts,
   output bfip_pkg::bfip_cmd_type cmd
);

   bfip_pkg::bfip_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bfip_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         bfip_pkg::ST_CLEAR: begin
            cmd.clear  = 1'b1;
            cmd.mem_wr = 1'b1;
            if (sts.clear_last) begin
               state_in = bfip_pkg::ST_IDLE;
            end
         end
         bfip_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               unique case (req_op) inside
                  bfip_pkg::OP_INSERT,
                  bfip_pkg::OP_PROBE,
                  bfip_pkg::OP_MERGE: state_in = bfip_pkg::ST_READ;
                  default:            state_in = bfip_pkg::ST_IDLE;
               endcase
            end
         end
         bfip_pkg::ST_READ: begin
            cmd.mem_rd = 1'b1;
            state_in   = bfip_pkg::ST_UPDATE;
         end
         bfip_pkg::ST_UPDATE: begin
            if (sts.op == bfip_pkg::OP_PROBE) begin
               cmd.check = 1'b1;
            end else begin
               cmd.mem_wr = 1'b1;
            end
            if (sts.op == bfip_pkg::OP_MERGE) begin
               state_in = bfip_pkg::ST_IDLE;
            end else if (!sts.last_hash) begin
               cmd.hash_next = 1'b1;
               state_in      = bfip_pkg::ST_READ;
            end else if (sts.op == bfip_pkg::OP_PROBE) begin
               state_in = bfip_pkg::ST_REPLY;
            end else begin
               state_in = bfip_pkg::ST_IDLE;
            end
         end
         bfip_pkg::ST_REPLY: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = bfip_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bfip_pkg::ST_IDLE;
         end
      endcase
   end

   // nothing is taken in while the store is being cleared
   a_no_load_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == bfip_pkg::ST_CLEAR |-> !cmd.load)
      else $error("item accepted during clearing pass");

   // a result only goes out when the output register can take it
   a_rsp_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> sts.rsp_free)
      else $error("probe result would overwrite a pending result");

   // only probes reach the reply state
   a_reply_probe_only: assert property (@(posedge clock) disable iff (reset)
      state_ff == bfip_pkg::ST_REPLY |-> sts.op == bfip_pkg::OP_PROBE)
      else $error("reply state reached by a non-probe item");

   // merge is one read-modify-write, then back to idle
   a_merge_single_pass: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bfip_pkg::ST_UPDATE && sts.op == bfip_pkg::OP_MERGE)
      |=> state_ff == bfip_pkg::ST_IDLE)
      else $error("merge did not finish after one write");

endmodule

// File: sv/bfip_dp.sv
module bfip_dp #(
   parameter int LOG2_BITS = bfip_pkg::LOG2_BITS_DEF,
   parameter int HASHES    = bfip_pkg::HASHES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bfip_pkg::bfip_cmd_type        cmd,
   output bfip_pkg::bfip_sts_type        sts,
   input  bfip_pkg::bfip_op_type         req_op,
   input  logic [bfip_pkg::HASH_W-1:0]   req_hash,
   input  logic [bfip_pkg::INDEX_W-1:0]  req_word_index,
   input  logic [bfip_pkg::WORD_W-1:0]   req_word_data,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic                          rsp_maybe_present
);

   localparam int AW    = (LOG2_BITS > bfip_pkg::OFFSET_W) ? LOG2_BITS - bfip_pkg::OFFSET_W : 1;
   localparam int DEPTH = 1 << AW;
   localparam int WORDS = 1 << (LOG2_BITS - bfip_pkg::OFFSET_W);
   localparam int HC_W  = (HASHES > 1) ? $clog2(HASHES) : 1;
   localparam logic [HC_W-1:0] HC_LAST = HC_W'(HASHES - 1);

   bfip_pkg::bfip_op_type             op_ff;
   logic [bfip_pkg::HASH_W-1:0]       hash_ff;
   logic [bfip_pkg::INDEX_W-1:0]      widx_ff;
   logic [bfip_pkg::WORD_W-1:0]       wdata_ff;
   logic [HC_W-1:0]                   hc_ff;
   logic [AW-1:0]                     clr_ff;
   logic                              hit_ff;
   logic                              rsp_valid_ff;
   logic                              rsp_bit_ff;

   logic [LOG2_BITS-1:0]              idx_all [HASHES];
   logic [LOG2_BITS-1:0]              idx;
   logic [bfip_pkg::OFFSET_W-1:0]     offset;
   logic [AW-1:0]                     hash_addr;
   logic [AW-1:0]                     merge_addr;
   logic [63:0]                       widx_ext;
   logic [bfip_pkg::WORD_W-1:0]       bit_mask;

   logic                              mem_en;
   logic [AW-1:0]                     mem_addr;
   logic [bfip_pkg::WORD_W-1:0]       mem_wdata;
   logic [bfip_pkg::WORD_W-1:0]       mem_rdata;

   // bit index of each hash function, constant shift per function
   for (genvar g = 0; g < HASHES; g++) begin : g_idx
      localparam int START = g * LOG2_BITS;
      if (START >= bfip_pkg::HASH_W) begin : g_zero
         assign idx_all[g] = '0;
      end else begin : g_field
         assign idx_all[g] = LOG2_BITS'(hash_ff >> START);
      end
   end

   assign idx        = idx_all[hc_ff];
   assign offset     = idx[bfip_pkg::OFFSET_W-1:0];
   assign hash_addr  = AW'(idx >> bfip_pkg::OFFSET_W);
   assign widx_ext   = 64'(widx_ff);
   assign merge_addr = AW'(widx_ext & 64'(WORDS - 1));
   assign bit_mask   = bfip_pkg::WORD_W'(1) << offset;

   always_comb begin
      if (cmd.clear) begin
         mem_addr  = clr_ff;
         mem_wdata = '0;
      end else if (op_ff == bfip_pkg::OP_MERGE) begin
         mem_addr  = merge_addr;
         mem_wdata = mem_rdata | wdata_ff;
      end else begin
         mem_addr  = hash_addr;
         mem_wdata = mem_rdata | bit_mask;
      end
   end

   assign mem_en = cmd.mem_rd | cmd.mem_wr;

   bfip_ram #(
      .WIDTH (bfip_pkg::WORD_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .en    (mem_en),
      .we    (cmd.mem_wr),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   // item registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         hash_ff  <= req_hash;
         widx_ff  <= req_word_index;
         wdata_ff <= req_word_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff  <= bfip_pkg::OP_NONE;
         hc_ff  <= '0;
         clr_ff <= '0;
         hit_ff <= 1'b1;
      end else begin
         if (cmd.load) begin
            op_ff  <= req_op;
            hc_ff  <= '0;
            hit_ff <= 1'b1;
         end else begin
            if (cmd.hash_next) begin
               hc_ff <= hc_ff + 1'b1;
            end
            if (cmd.check) begin
               hit_ff <= hit_ff & mem_rdata[offset];
            end
         end
         if (cmd.clear) begin
            clr_ff <= clr_ff + 1'b1;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_bit_ff <= hit_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_maybe_present = rsp_bit_ff;

   assign sts.op         = op_ff;
   assign sts.last_hash  = (hc_ff == HC_LAST);
   assign sts.clear_last = (clr_ff == {AW{1'b1}});
   assign sts.rsp_free   = !rsp_valid_ff || rsp_ready;

endmodule

// File: sv/bloom_filter_insert_probe_core.sv
// bloom filter over a bit store of 2^LOG2_BITS bits, held as 64-bit words in one
// single-port ram with registered read
//
// req_chan: one item per valid/ready handshake; req_type selects insert (0),
//   probe (1) or merge (2); code 3 is taken and dropped
// rsp_chan: one item per probe, maybe_present = 1 when every chosen bit is set
//
// each hash function costs one read and one update of a word on the ram port; insert
//   and probe repeat this for all HASHES functions, then a probe loads its result into
//   the output register; merge does a single read and update of the word at word_index
// one item is in work at a time; req_chan.ready is high only between items
//
// after reset the store is swept to zero, one word per cycle, over all
//   2^(LOG2_BITS-6) words (4096 at the default); req_chan.ready stays low
//
// the probe result sits in an output register; while rsp_chan stalls the next
// item is still accepted and worked, and only a second probe result waits
module bloom_filter_insert_probe_core #(
   parameter int LOG2_BITS = bfip_pkg::LOG2_BITS_DEF,
   parameter int HASHES    = bfip_pkg::HASHES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   bfip_req_if.sink    req_chan,
   bfip_rsp_if.source  rsp_chan
);

   bfip_pkg::bfip_cmd_type cmd;   // controller commands
   bfip_pkg::bfip_sts_type sts;   // datapath status
   bfip_pkg::bfip_op_type  req_op;

   // raw selector as an operation code
   assign req_op = bfip_pkg::bfip_op_type'(req_chan.req_type);

   // sequencer: clear sweep, per-hash read / update, reply
   bfip_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_op    (req_op),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // item registers, bit index selection, ram and output register
   bfip_dp #(
      .LOG2_BITS (LOG2_BITS),
      .HASHES    (HASHES)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_op            (req_op),
      .req_hash          (req_chan.hash),
      .req_word_index    (req_chan.word_index),
      .req_word_data     (req_chan.word_data),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_maybe_present (rsp_chan.maybe_present)
   );

endmodule
